// ===== rtl/lfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types and constants of the led fade sequencer.
// ----------------------------------------------------------------------------
package lfs_pkg;

    localparam int TIMER_BITS_DEFAULT = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_UP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DOWN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_PERIOD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_PERIOD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 3'd7;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PH_WAIT     = 2'd0,
        PH_FADE_IN  = 2'd1,
        PH_HOLD     = 2'd2,
        PH_FADE_OUT = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0]  min_level;
        logic [7:0]  max_level;
        logic [7:0]  step_up;
        logic [7:0]  step_down;
        logic [15:0] up_period;
        logic [15:0] down_period;
        logic [15:0] hold_time;
        logic [15:0] start_delay;
    } cfg_t;

    typedef struct packed {
        logic [7:0] level;
        logic       running;
        phase_t     phase;
    } status_t;

endpackage

// ===== rtl/lfs_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfs_cfg_regs
// Configuration register file: fade bounds, step sizes and tick periods.
// ----------------------------------------------------------------------------
module lfs_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [lfs_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [lfs_pkg::CFG_DATA_W-1:0] wr_data,
    output lfs_pkg::cfg_t                  cfg
);
    import lfs_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_level   <= 8'd0;
            cfg_reg.max_level   <= 8'd0;
            cfg_reg.step_up     <= 8'd1;
            cfg_reg.step_down   <= 8'd1;
            cfg_reg.up_period   <= 16'd0;
            cfg_reg.down_period <= 16'd0;
            cfg_reg.hold_time   <= 16'd0;
            cfg_reg.start_delay <= 16'd0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_MIN_LEVEL:   cfg_reg.min_level   <= wr_data[7:0];
                CFG_MAX_LEVEL:   cfg_reg.max_level   <= wr_data[7:0];
                CFG_STEP_UP:     cfg_reg.step_up     <= wr_data[7:0];
                CFG_STEP_DOWN:   cfg_reg.step_down   <= wr_data[7:0];
                CFG_UP_PERIOD:   cfg_reg.up_period   <= wr_data;
                CFG_DOWN_PERIOD: cfg_reg.down_period <= wr_data;
                CFG_HOLD_TIME:   cfg_reg.hold_time   <= wr_data;
                CFG_START_DELAY: cfg_reg.start_delay <= wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/lfs_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfs_engine
// Fade state machine: tick timer, level stepping with clamps, start/stop.
// ----------------------------------------------------------------------------
module lfs_engine #(
    parameter int TIMER_BITS = lfs_pkg::TIMER_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  logic [1:0]       op,
    input  logic             loop_mode,
    input  lfs_pkg::cfg_t    cfg,
    output lfs_pkg::status_t status_next
);
    import lfs_pkg::*;

    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    logic                  active_reg,  active_next;
    logic                  repeat_reg,  repeat_next;
    phase_t                phase_reg,   phase_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic [7:0]            next_lvl_reg, next_lvl_next;
    logic [7:0]            shown_reg,   shown_next;

    logic [TIMER_BITS-1:0] elapsed_inc;
    logic [CMP_W-1:0]      elapsed_cmp;
    logic [8:0]            up_sum;
    logic [8:0]            down_diff;
    logic [7:0]            up_level;
    logic [7:0]            down_level;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            repeat_reg   <= 1'b0;
            phase_reg    <= PH_WAIT;
            elapsed_reg  <= '0;
            next_lvl_reg <= '0;
            shown_reg    <= '0;
        end
        else if (step_en)
        begin
            active_reg   <= active_next;
            repeat_reg   <= repeat_next;
            phase_reg    <= phase_next;
            elapsed_reg  <= elapsed_next;
            next_lvl_reg <= next_lvl_next;
            shown_reg    <= shown_next;
        end
    end

    // saturating tick count
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
    assign elapsed_cmp = CMP_W'(elapsed_inc);

    assign up_sum     = {1'b0, next_lvl_reg} + {1'b0, cfg.step_up};
    assign up_level   = (up_sum > {1'b0, cfg.max_level}) ? cfg.max_level : up_sum[7:0];
    assign down_diff  = {1'b0, next_lvl_reg} - {1'b0, cfg.step_down};
    // borrow or below the floor clamps to min
    assign down_level = (down_diff[8] || (down_diff[7:0] < cfg.min_level)) ?
                        cfg.min_level : down_diff[7:0];

    always_comb
    begin
        active_next   = active_reg;
        repeat_next   = repeat_reg;
        phase_next    = phase_reg;
        elapsed_next  = elapsed_reg;
        next_lvl_next = next_lvl_reg;
        shown_next    = shown_reg;

        unique case (op)
            OP_TICK:
            begin
                if (active_reg)
                begin
                    elapsed_next = elapsed_inc;
                    unique case (phase_reg)
                        PH_WAIT:
                        begin
                            if (elapsed_cmp > CMP_W'(cfg.start_delay))
                            begin
                                next_lvl_next = cfg.min_level;
                                phase_next    = PH_FADE_IN;
                                elapsed_next  = '0;
                            end
                        end
                        PH_FADE_IN:
                        begin
                            if (elapsed_cmp >= CMP_W'(cfg.up_period))
                            begin
                                elapsed_next = '0;
                                shown_next   = next_lvl_reg;
                                if (next_lvl_reg == cfg.max_level)
                                    phase_next = PH_HOLD;
                                else
                                    next_lvl_next = up_level;
                            end
                        end
                        PH_HOLD:
                        begin
                            if (elapsed_cmp >= CMP_W'(cfg.hold_time))
                            begin
                                elapsed_next = '0;
                                phase_next   = (next_lvl_reg == cfg.max_level) ?
                                               PH_FADE_OUT : PH_FADE_IN;
                            end
                        end
                        PH_FADE_OUT:
                        begin
                            if (elapsed_cmp >= CMP_W'(cfg.down_period))
                            begin
                                elapsed_next = '0;
                                shown_next   = next_lvl_reg;
                                if (next_lvl_reg == cfg.min_level)
                                begin
                                    phase_next = PH_HOLD;
                                    // single run ends here
                                    if (!repeat_reg)
                                    begin
                                        active_next   = 1'b0;
                                        repeat_next   = 1'b0;
                                        phase_next    = PH_WAIT;
                                        next_lvl_next = '0;
                                        shown_next    = '0;
                                    end
                                end
                                else
                                begin
                                    next_lvl_next = down_level;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_START:
            begin
                active_next  = 1'b1;
                repeat_next  = loop_mode;
                elapsed_next = '0;
            end
            OP_STOP:
            begin
                active_next   = 1'b0;
                repeat_next   = 1'b0;
                phase_next    = PH_WAIT;
                elapsed_next  = '0;
                next_lvl_next = '0;
                shown_next    = '0;
            end
            default: ;
        endcase
    end

    assign status_next.level   = shown_next;
    assign status_next.running = active_next;
    assign status_next.phase   = phase_next;

    // an idle engine always sits fully cleared
    a_idle_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (elapsed_reg == '0 && phase_reg == PH_WAIT &&
                         shown_reg == '0 && next_lvl_reg == '0 && !repeat_reg))
        else $error("idle engine holds stale state");

    a_stop_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && op == OP_STOP) |=> (!active_reg && shown_reg == '0))
        else $error("stop did not halt the animation");

    a_start_arms: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && op == OP_START) |=>
            (active_reg && elapsed_reg == '0 && repeat_reg == $past(loop_mode)))
        else $error("start did not arm the animation");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> ($stable(active_reg) && $stable(phase_reg) &&
                      $stable(elapsed_reg) && $stable(shown_reg) &&
                      $stable(next_lvl_reg)))
        else $error("state moved without a word");

    a_level_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && op == OP_TICK && active_reg && phase_reg == PH_FADE_IN &&
         cfg.min_level <= cfg.max_level && next_lvl_reg <= cfg.max_level)
            |=> (next_lvl_reg <= $past(cfg.max_level)))
        else $error("fade-in level passed the ceiling");

endmodule

// ===== rtl/led_fade_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_fade_sequencer_core
// Breathing fade controller for one LED, driven by tick/start/stop words.
// ----------------------------------------------------------------------------
// One input word (a millisecond tick, a start or a stop) is taken every clock
// cycle unless stalled; each word yields one result word carrying the driven
// level, the running flag and the phase after the update. An input register
// feeds a single-pass update of the fade state, whose outcome lands in a
// result register, so the next word is accepted while a finished result still
// waits to be taken. The user must write configuration through its own port,
// one register per word, while no word is in flight; the core does not check.
module led_fade_sequencer_core #(
    parameter int TIMER_BITS = lfs_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lfs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     op,
    input  logic                           loop_mode,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     drive_level,
    output logic                           running,
    output logic [1:0]                     phase
);
    import lfs_pkg::*;

    cfg_t    cfg;
    status_t status_next;

    logic       in_valid_reg;
    logic [1:0] op_reg;
    logic       loop_reg;
    logic       out_valid_reg;
    status_t    out_reg;
    logic       advance;

    assign cfg_ready = 1'b1;

    lfs_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // a held word moves on when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= op;
            loop_reg <= loop_mode;
        end
    end

    lfs_engine #(
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .op          (op_reg),
        .loop_mode   (loop_reg),
        .cfg         (cfg),
        .status_next (status_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= status_next;
    end

    assign out_valid   = out_valid_reg;
    assign drive_level = out_reg.level;
    assign running     = out_reg.running;
    assign phase       = out_reg.phase;

endmodule

// ===== verif/tb_led_fade_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_fade_sequencer_core
// Self-checking testbench for the led fade sequencer core.
// ----------------------------------------------------------------------------
// A behavioral copy of the fade state machine predicts the status word for
// every tick, start and stop word that the core accepts. A checker process
// compares each returned word field by field against the oldest prediction.
// Directed tests cover the reset settings, a single run, inverted bounds,
// zero steps and all-ones settings. A long output stall follows, then random
// fades under three idle mixes on both handshakes.
// ----------------------------------------------------------------------------
module tb_led_fade_sequencer_core;

    import lfs_pkg::*;

    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int MAX_PRINTED     = 30;

    // op code that the core leaves unused
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            op;
    logic                  loop_mode;
    logic                  out_valid;
    logic                  out_ready;
    logic [7:0]            drive_level;
    logic                  running;
    logic [1:0]            phase;

    led_fade_sequencer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .loop_mode   (loop_mode),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .drive_level (drive_level),
        .running     (running),
        .phase       (phase)
    );

    // predicted fade state
    cfg_t                          fade_cfg;
    logic                          fade_on;
    phase_t                        fade_phase;
    logic [TIMER_BITS_DEFAULT-1:0] tick_count;
    logic [7:0]                    level_next;
    logic [7:0]                    level_shown;
    logic                          fade_repeat;

    status_t expected_status_q[$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  word_count    = 0;
    int  result_count  = 0;
    int  cfg_loads     = 0;
    int  err_count     = 0;
    logic recv_hold;
    event hold_off_go;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_PRINTED)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    function automatic void clear_fade();
        fade_on     = 1'b0;
        fade_phase  = PH_WAIT;
        tick_count  = '0;
        level_next  = 8'd0;
        level_shown = 8'd0;
        fade_repeat = 1'b0;
    endfunction

    task automatic reset_model();
        fade_cfg             = '0;
        fade_cfg.step_up     = 8'd1;
        fade_cfg.step_down   = 8'd1;
        clear_fade();
    endtask

    // one accepted word: update the predicted state, return the status after it
    function automatic status_t advance_fade(input logic [1:0] word_op, input logic word_loop);
        logic [8:0] sum;
        status_t    s;
        case (word_op)
            OP_TICK:
            begin
                if (fade_on)
                begin
                    if (tick_count != '1)
                        tick_count = tick_count + 1'b1;
                    case (fade_phase)
                        PH_WAIT:
                        begin
                            if (tick_count > fade_cfg.start_delay)
                            begin
                                level_next = fade_cfg.min_level;
                                fade_phase = PH_FADE_IN;
                                tick_count = '0;
                            end
                        end
                        PH_FADE_IN:
                        begin
                            if (tick_count >= fade_cfg.up_period)
                            begin
                                tick_count  = '0;
                                level_shown = level_next;
                                if (level_next == fade_cfg.max_level)
                                    fade_phase = PH_HOLD;
                                else
                                begin
                                    sum = level_next + fade_cfg.step_up;
                                    level_next = (sum > fade_cfg.max_level) ?
                                                 fade_cfg.max_level : sum[7:0];
                                end
                            end
                        end
                        PH_HOLD:
                        begin
                            if (tick_count >= fade_cfg.hold_time)
                            begin
                                tick_count = '0;
                                fade_phase = (level_next == fade_cfg.max_level) ?
                                             PH_FADE_OUT : PH_FADE_IN;
                            end
                        end
                        default:
                        begin
                            if (tick_count >= fade_cfg.down_period)
                            begin
                                tick_count  = '0;
                                level_shown = level_next;
                                if (level_next == fade_cfg.min_level)
                                begin
                                    fade_phase = PH_HOLD;
                                    if (!fade_repeat)
                                        clear_fade();
                                end
                                else if (fade_cfg.step_down > level_next ||
                                         level_next - fade_cfg.step_down < fade_cfg.min_level)
                                    level_next = fade_cfg.min_level;
                                else
                                    level_next = level_next - fade_cfg.step_down;
                            end
                        end
                    endcase
                end
            end
            OP_START:
            begin
                // a restart keeps phase and levels; only the timer and the loop flag are set anew
                fade_on     = 1'b1;
                fade_repeat = word_loop;
                tick_count  = '0;
            end
            OP_STOP:
                clear_fade();
            default: ;
        endcase
        s.level   = level_shown;
        s.running = fade_on;
        s.phase   = fade_phase;
        return s;
    endfunction

    function automatic cfg_t make_cfg(input logic [7:0] lo, input logic [7:0] hi,
                                      input logic [7:0] up_step, input logic [7:0] down_step,
                                      input logic [15:0] up_ticks, input logic [15:0] down_ticks,
                                      input logic [15:0] hold_ticks, input logic [15:0] delay);
        cfg_t c;
        c.min_level   = lo;
        c.max_level   = hi;
        c.step_up     = up_step;
        c.step_down   = down_step;
        c.up_period   = up_ticks;
        c.down_period = down_ticks;
        c.hold_time   = hold_ticks;
        c.start_delay = delay;
        return c;
    endfunction

    function automatic logic [7:0] pick_step();
        return ($urandom_range(3) == 0) ? 8'($urandom_range(255, 1)) : 8'($urandom_range(80, 12));
    endfunction

    // mostly short periods so fades finish, now and then any 16-bit value
    function automatic logic [15:0] pick_ticks();
        return ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    endfunction

    function automatic cfg_t random_config();
        cfg_t       c;
        logic [7:0] swap;
        c = make_cfg(8'($urandom_range(255)), 8'($urandom_range(255)), pick_step(), pick_step(),
                     pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
        // keep inverted bounds in only about a quarter of the draws that come out inverted
        if (c.min_level > c.max_level && $urandom_range(3) != 0)
        begin
            swap        = c.min_level;
            c.min_level = c.max_level;
            c.max_level = swap;
        end
        return c;
    endfunction

    // lowers in_valid, then waits until every predicted word has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_MIN_LEVEL:   fade_cfg.min_level   = data[7:0];
            CFG_MAX_LEVEL:   fade_cfg.max_level   = data[7:0];
            CFG_STEP_UP:     fade_cfg.step_up     = data[7:0];
            CFG_STEP_DOWN:   fade_cfg.step_down   = data[7:0];
            CFG_UP_PERIOD:   fade_cfg.up_period   = data;
            CFG_DOWN_PERIOD: fade_cfg.down_period = data;
            CFG_HOLD_TIME:   fade_cfg.hold_time   = data;
            CFG_START_DELAY: fade_cfg.start_delay = data;
            default: ;
        endcase
    endtask

    // byte registers get random upper bits, which the core must drop
    task automatic load_config(input cfg_t c);
        wait_idle();
        put_reg(CFG_MIN_LEVEL,   {8'($urandom_range(255)), c.min_level});
        put_reg(CFG_MAX_LEVEL,   {8'($urandom_range(255)), c.max_level});
        put_reg(CFG_STEP_UP,     {8'($urandom_range(255)), c.step_up});
        put_reg(CFG_STEP_DOWN,   {8'($urandom_range(255)), c.step_down});
        put_reg(CFG_UP_PERIOD,   c.up_period);
        put_reg(CFG_DOWN_PERIOD, c.down_period);
        put_reg(CFG_HOLD_TIME,   c.hold_time);
        put_reg(CFG_START_DELAY, c.start_delay);
        cfg_valid <= 1'b0;
        cfg_loads++;
    endtask

    task automatic send_word(input logic [1:0] word_op, input logic word_loop);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= word_op;
        loop_mode <= word_loop;
        do @(posedge clk); while (!in_ready);
        expected_status_q.push_back(advance_fade(word_op, word_loop));
        word_count++;
    endtask

    task automatic send_ticks(input int n);
        for (int i = 0; i < n; i++)
            send_word(OP_TICK, 1'($urandom_range(1)));
    endtask

    // reset settings: everything collapses onto level zero
    task automatic test_defaults();
        send_word(OP_TICK, 1'b1);
        send_word(OP_UNUSED, 1'b0);
        send_word(OP_START, 1'b1);
        send_ticks(3);
        send_word(OP_STOP, 1'b0);
    endtask

    // one full run without looping, largest steps, ends by itself
    task automatic test_single_run();
        load_config(make_cfg(8'd10, 8'd250, 8'd255, 8'd255, 16'd0, 16'd0, 16'd0, 16'd0));
        send_word(OP_START, 1'b0);
        send_ticks(6);
    endtask

    // min above max, restart while active, unused op while active
    task automatic test_inverted_bounds();
        load_config(make_cfg(8'd200, 8'd50, 8'd1, 8'd1, 16'd0, 16'd0, 16'd1, 16'd0));
        send_word(OP_START, 1'b1);
        send_ticks(4);
        send_word(OP_START, 1'b0);
        send_word(OP_UNUSED, 1'b1);
        send_word(OP_STOP, 1'b1);
    endtask

    // zero steps keep the level still, then all-ones settings
    task automatic test_extreme_settings();
        load_config(make_cfg(8'd0, 8'd255, 8'd0, 8'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0));
        send_word(OP_START, 1'b1);
        send_ticks(2);
        send_word(OP_STOP, 1'b0);
        load_config(make_cfg(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_word(OP_START, 1'b0);
        send_ticks(1);
        send_word(OP_STOP, 1'b1);
    endtask

    // output held off while words keep coming, so the core stalls its input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_config(make_cfg(8'd0, 8'd200, 8'd40, 8'd40, 16'd1, 16'd1, 16'd2, 16'd1));
        -> hold_off_go;
        send_word(OP_START, 1'b1);
        send_ticks(40);
        wait_idle();
    endtask

    task automatic test_random_fades(input int send_pct, input int recv_pct, input int words);
        int         counted;
        int         r;
        logic [1:0] word_op;
        wait_idle();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int k = 0; k < 4; k++)
        begin
            load_config(random_config());
            counted = 0;
            while (counted < words / 4)
            begin
                r = $urandom_range(99);
                if (!fade_on)
                    word_op = (r < 60) ? OP_START : (r < 80) ? OP_TICK :
                              (r < 90) ? OP_UNUSED : OP_STOP;
                else
                    word_op = (r < 88) ? OP_TICK : (r < 93) ? OP_START :
                              (r < 97) ? OP_STOP : OP_UNUSED;
                // ticks and stops to an idle core change nothing
                if (fade_on || word_op == OP_START)
                    counted++;
                send_word(word_op, 1'($urandom_range(1)));
            end
        end
    endtask

    initial
    begin
        recv_hold = 1'b0;
        forever
        begin
            @(hold_off_go);
            @(posedge clk);
            recv_hold <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clk);
            recv_hold <= 1'b0;
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || recv_hold)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        status_t want;
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (expected_status_q.size() == 0)
                report_mismatch("result word with no prediction pending");
            else
            begin
                want = expected_status_q.pop_front();
                if (drive_level !== want.level)
                    report_mismatch($sformatf("drive_level got %0d expected %0d",
                                              drive_level, want.level));
                if (running !== want.running)
                    report_mismatch($sformatf("running got %0b expected %0b",
                                              running, want.running));
                if (phase !== want.phase)
                    report_mismatch($sformatf("phase got %0d expected %0d",
                                              phase, want.phase));
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        op        = OP_TICK;
        loop_mode = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_MIN_LEVEL;
        cfg_data  = '0;
        reset_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_single_run();
        test_inverted_bounds();
        test_extreme_settings();
        test_backpressure();
        test_random_fades(22, 82, 600);
        test_random_fades(82, 22, 600);
        test_random_fades(0, 0, 600);
        wait_idle();

        $display("sent %0d words over %0d register loads: directed fades, a long output stall,",
                 word_count, cfg_loads);
        $display("random fades under three idle mixes; %0d result words checked, %0d mismatches",
                 result_count, err_count);
        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
